### hdl/ptc_pkg.sv
// Shared types, constants and helpers for the pressure/temperature compensation block.
`default_nettype none
package ptc_pkg;

    // Pipelined divider geometry
    localparam int DIV_W  = 32;
    localparam int SIDE_W = 50;

    // Compensation constants
    localparam logic signed [31:0] TEMP_OFFSET_B6 = 32'sd4000;
    localparam logic        [31:0] PRESS_SCALE    = 32'd50000;
    localparam logic signed [31:0] B4_BIAS        = 32'sd32768;
    localparam logic signed [31:0] P_SQ_COEF      = 32'sd3038;
    localparam logic signed [31:0] P_LIN_COEF     = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET       = 32'sd3791;
    localparam logic        [31:0] B7_LIMIT       = 32'h8000_0000;

    localparam logic signed [15:0] T_MAX = 16'sh7fff;
    localparam logic signed [15:0] T_MIN = 16'sh8000;
    localparam logic        [19:0] P_MAX = 20'hfffff;

    // Calibration register indexes
    typedef enum logic [2:0] {
        REG_AC1   = 3'd0,
        REG_AC2   = 3'd1,
        REG_AC3   = 3'd2,
        REG_AC4   = 3'd3,
        REG_AC5   = 3'd4,
        REG_AC6   = 3'd5,
        REG_B1_B2 = 3'd6,
        REG_MC_MD = 3'd7
    } cal_index_t;

    // Calibration reset values
    localparam logic [15:0] RST_AC1   = 16'd408;
    localparam logic [15:0] RST_AC2   = 16'hffb8;
    localparam logic [15:0] RST_AC3   = 16'hc7d1;
    localparam logic [15:0] RST_AC4   = 16'd32741;
    localparam logic [15:0] RST_AC5   = 16'd32757;
    localparam logic [15:0] RST_AC6   = 16'd23153;
    localparam logic [31:0] RST_B1_B2 = 32'd405667844;
    localparam logic [31:0] RST_MC_MD = 32'd3724086068;

    // Divider request and response
    typedef struct packed {
        logic              valid;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
        logic [SIDE_W-1:0] side;
    } ptc_div_req_t;

    typedef struct packed {
        logic              valid;
        logic [DIV_W-1:0]  quot;
        logic [SIDE_W-1:0] side;
    } ptc_div_rsp_t;

    // Signed divide by 2**k, truncating toward zero
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] v,
                                                   input int unsigned k);
        logic signed [31:0] bias;
        bias = v[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (v + bias) >>> k;
    endfunction

endpackage
`default_nettype wire

### hdl/ptc_if.sv
// Valid/ready channel interfaces for raw samples and compensated results.
`default_nettype none
interface ptc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic        [19:0] pressure_pa;

    modport source (output valid, output temperature_tenths, output pressure_pa, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa, output ready);
endinterface
`default_nettype wire

### hdl/ptc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with side payload.
`default_nettype none
module ptc_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire ptc_pkg::ptc_div_req_t req,
    output ptc_pkg::ptc_div_rsp_t      rsp
);
    import ptc_pkg::*;

    logic              valid_reg [DIV_W];
    logic [DIV_W-1:0]  rem_reg   [DIV_W];
    logic [DIV_W-1:0]  nq_reg    [DIV_W];
    logic [DIV_W-1:0]  den_reg   [DIV_W];
    logic [SIDE_W-1:0] side_reg  [DIV_W];

    logic              valid_next [DIV_W];
    logic [DIV_W-1:0]  rem_next   [DIV_W];
    logic [DIV_W-1:0]  nq_next    [DIV_W];
    logic [DIV_W-1:0]  den_next   [DIV_W];
    logic [SIDE_W-1:0] side_next  [DIV_W];

    // One shift/compare/subtract step per stage
    always_comb
    begin
        for (int i = 0; i < DIV_W; i++)
        begin
            logic [DIV_W-1:0] s_rem;
            logic [DIV_W-1:0] s_nq;
            logic [DIV_W:0]   trial;
            if (i == 0)
            begin
                valid_next[i] = req.valid;
                s_rem         = '0;
                s_nq          = req.num;
                den_next[i]   = req.den;
                side_next[i]  = req.side;
            end
            else
            begin
                valid_next[i] = valid_reg[i-1];
                s_rem         = rem_reg[i-1];
                s_nq          = nq_reg[i-1];
                den_next[i]   = den_reg[i-1];
                side_next[i]  = side_reg[i-1];
            end
            trial = {s_rem, s_nq[DIV_W-1]};
            if (trial >= {1'b0, den_next[i]})
            begin
                rem_next[i] = DIV_W'(trial - {1'b0, den_next[i]});
                nq_next[i]  = {s_nq[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[DIV_W-1:0];
                nq_next[i]  = {s_nq[DIV_W-2:0], 1'b0};
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                nq_reg[i]   <= nq_next[i];
                den_reg[i]  <= den_next[i];
                side_reg[i] <= side_next[i];
            end
        end
    end

    assign rsp.valid = valid_reg[DIV_W-1];
    assign rsp.quot  = nq_reg[DIV_W-1];
    assign rsp.side  = side_reg[DIV_W-1];

endmodule
`default_nettype wire

### hdl/pressure_temperature_compensation.sv
// Top level: calibration registers and the compensation pipeline.
//
// Integer barometric compensation, oversampling 0. One raw temperature/pressure
// transaction is accepted every cycle and each yields one result transaction,
// in order. Each transaction passes through 75 register stages: 11 arithmetic
// stages plus two 32-stage pipelined dividers, one for the temperature term
// MC*2048/(X1+MD) and one for the B7/B4 pressure quotient. The whole pipeline
// advances together. It holds when a result waits at the output and is not taken.
// Calibration registers reset to the stock coefficients. The user must write them
// through cfg_we/cfg_index/cfg_data only while no transaction is in flight; the
// block itself does not enforce this.
`default_nettype none
module pressure_temperature_compensation (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire ptc_pkg::cal_index_t cfg_index,
    input  wire logic [31:0]         cfg_data,
    ptc_in_if.sink                   samples,
    ptc_out_if.source                results
);
    import ptc_pkg::*;

    // Calibration registers
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b1_b2_reg, mc_md_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg   <= RST_AC1;
            ac2_reg   <= RST_AC2;
            ac3_reg   <= RST_AC3;
            ac4_reg   <= RST_AC4;
            ac5_reg   <= RST_AC5;
            ac6_reg   <= RST_AC6;
            b1_b2_reg <= RST_B1_B2;
            mc_md_reg <= RST_MC_MD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AC1:   ac1_reg   <= cfg_data[15:0];
                REG_AC2:   ac2_reg   <= cfg_data[15:0];
                REG_AC3:   ac3_reg   <= cfg_data[15:0];
                REG_AC4:   ac4_reg   <= cfg_data[15:0];
                REG_AC5:   ac5_reg   <= cfg_data[15:0];
                REG_AC6:   ac6_reg   <= cfg_data[15:0];
                REG_B1_B2: b1_b2_reg <= cfg_data;
                REG_MC_MD: mc_md_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Sign-extended coefficients
    logic signed [31:0] ac1_s, ac2_s, ac3_s, b1_s, b2_s, mc_s, md_s;
    assign ac1_s = $signed({{16{ac1_reg[15]}}, ac1_reg});
    assign ac2_s = $signed({{16{ac2_reg[15]}}, ac2_reg});
    assign ac3_s = $signed({{16{ac3_reg[15]}}, ac3_reg});
    assign b1_s  = $signed({{16{b1_b2_reg[31]}}, b1_b2_reg[31:16]});
    assign b2_s  = $signed({{16{b1_b2_reg[15]}}, b1_b2_reg[15:0]});
    assign mc_s  = $signed({{16{mc_md_reg[31]}}, mc_md_reg[31:16]});
    assign md_s  = $signed({{16{mc_md_reg[15]}}, mc_md_reg[15:0]});

    // Global advance: move unless the output holds an untaken result
    logic m_valid_reg;
    logic en;
    assign en            = !m_valid_reg || results.ready;
    assign samples.ready = en;

    // Valid bits of the arithmetic stages
    logic a_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    logic g_valid_reg, h_valid_reg, i_valid_reg, k_valid_reg, l_valid_reg;
    ptc_div_req_t tdiv_req, pdiv_req;
    ptc_div_rsp_t tdiv_rsp, pdiv_rsp;

    // ---- Stage A: (UT - AC6) * AC5
    logic signed [17:0] a_diff;
    logic signed [35:0] a_prod_next;
    logic signed [31:0] a_prod_reg;
    logic        [15:0] a_up_reg;
    assign a_diff      = $signed({2'b00, samples.raw_temperature}) - $signed({2'b00, ac6_reg});
    assign a_prod_next = a_diff * $signed({2'b00, ac5_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod_next[31:0];
            a_up_reg   <= samples.raw_pressure;
        end
    end

    // ---- Stage B: X1, divisor X1+MD, operand magnitudes into the divider
    logic signed [31:0] b_x1, b_den, b_num;
    logic        [31:0] b_num_abs, b_den_abs;
    assign b_x1      = sdiv_p2(a_prod_reg, 15);
    assign b_den     = b_x1 + md_s;
    assign b_num     = mc_s <<< 11;
    assign b_num_abs = b_num[31] ? 32'(-b_num) : b_num;
    assign b_den_abs = b_den[31] ? 32'(-b_den) : b_den;

    assign tdiv_req.valid = a_valid_reg;
    assign tdiv_req.num   = b_num_abs;
    assign tdiv_req.den   = b_den_abs;
    assign tdiv_req.side  = {b_x1, a_up_reg, b_num[31] ^ b_den[31], b_den == 32'sd0};

    ptc_div u_tdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (tdiv_req),
        .rsp   (tdiv_rsp)
    );

    // ---- Stage C: X2 with sign, B5
    logic signed [31:0] c_x1, c_x2;
    logic               c_neg, c_zero;
    logic        [15:0] c_up;
    logic signed [31:0] c_b5_reg;
    logic        [15:0] c_up_reg;
    assign {c_x1, c_up, c_neg, c_zero} = tdiv_rsp.side;
    assign c_x2 = c_zero ? 32'sd0 :
                  (c_neg ? -$signed(tdiv_rsp.quot) : $signed(tdiv_rsp.quot));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_b5_reg <= c_x1 + c_x2;
            c_up_reg <= c_up;
        end
    end

    // ---- Stage D: temperature out, B6
    logic signed [31:0] d_t;
    logic signed [15:0] d_t_sat;
    logic signed [15:0] d_t_reg;
    logic signed [31:0] d_b6_reg;
    logic        [15:0] d_up_reg;
    assign d_t = sdiv_p2(c_b5_reg + 32'sd8, 4);

    always_comb
    begin
        if (d_t > 32'sd32767)
        begin
            d_t_sat = T_MAX;
        end
        else if (d_t < -32'sd32768)
        begin
            d_t_sat = T_MIN;
        end
        else
        begin
            d_t_sat = d_t[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_t_reg  <= d_t_sat;
            d_b6_reg <= c_b5_reg - TEMP_OFFSET_B6;
            d_up_reg <= c_up_reg;
        end
    end

    // ---- Stage E: B6*B6, AC2*B6, AC3*B6
    logic signed [31:0] e_sqp_reg, e_ac2b6_reg, e_ac3b6_reg;
    logic signed [15:0] e_t_reg;
    logic        [15:0] e_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_sqp_reg   <= d_b6_reg * d_b6_reg;
            e_ac2b6_reg <= ac2_s * d_b6_reg;
            e_ac3b6_reg <= ac3_s * d_b6_reg;
            e_t_reg     <= d_t_reg;
            e_up_reg    <= d_up_reg;
        end
    end

    // ---- Stage F: scale the products
    logic signed [31:0] f_sq_reg, f_x2_reg, f_x1b_reg;
    logic signed [15:0] f_t_reg;
    logic        [15:0] f_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_sq_reg  <= sdiv_p2(e_sqp_reg, 12);
            f_x2_reg  <= sdiv_p2(e_ac2b6_reg, 11);
            f_x1b_reg <= sdiv_p2(e_ac3b6_reg, 13);
            f_t_reg   <= e_t_reg;
            f_up_reg  <= e_up_reg;
        end
    end

    // ---- Stage G: B2*SQ, B1*SQ
    logic signed [31:0] g_b2sq_reg, g_b1sq_reg, g_x2_reg, g_x1b_reg;
    logic signed [15:0] g_t_reg;
    logic        [15:0] g_up_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_b2sq_reg <= b2_s * f_sq_reg;
            g_b1sq_reg <= b1_s * f_sq_reg;
            g_x2_reg   <= f_x2_reg;
            g_x1b_reg  <= f_x1b_reg;
            g_t_reg    <= f_t_reg;
            g_up_reg   <= f_up_reg;
        end
    end

    // ---- Stage H: B3 and the B4 scale term
    logic signed [31:0] h_x3, h_x2b;
    logic signed [31:0] h_b3_reg, h_x3p_reg;
    logic signed [15:0] h_t_reg;
    logic        [15:0] h_up_reg;
    assign h_x3  = sdiv_p2(g_b2sq_reg, 11) + g_x2_reg;
    assign h_x2b = sdiv_p2(g_b1sq_reg, 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_b3_reg  <= sdiv_p2((ac1_s <<< 2) + h_x3 + 32'sd2, 2);
            h_x3p_reg <= sdiv_p2(g_x1b_reg + h_x2b + 32'sd2, 2);
            h_t_reg   <= g_t_reg;
            h_up_reg  <= g_up_reg;
        end
    end

    // ---- Stage I: B4 and B7
    logic [31:0] i_b4_prod, i_b7_next;
    logic [31:0] i_b4_reg, i_b7_reg;
    logic signed [15:0] i_t_reg;
    assign i_b4_prod = {16'd0, ac4_reg} * 32'(h_x3p_reg + B4_BIAS);
    assign i_b7_next = ({16'd0, h_up_reg} - 32'(h_b3_reg)) * PRESS_SCALE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_b4_reg <= i_b4_prod >> 15;
            i_b7_reg <= i_b7_next;
            i_t_reg  <= h_t_reg;
        end
    end

    // ---- Pressure quotient: scale B7 before or after the division
    logic i_high;
    assign i_high = i_b7_reg >= B7_LIMIT;

    assign pdiv_req.valid = i_valid_reg;
    assign pdiv_req.num   = i_high ? i_b7_reg : (i_b7_reg << 1);
    assign pdiv_req.den   = i_b4_reg;
    assign pdiv_req.side  = {(SIDE_W - 17)'(0), i_t_reg, i_high};

    ptc_div u_pdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (pdiv_req),
        .rsp   (pdiv_rsp)
    );

    // ---- Stage K: p, (p/256)^2, -7357*p
    logic signed [31:0] k_p, k_pd;
    logic signed [15:0] k_t;
    logic               k_high;
    logic signed [31:0] k_pdpd_reg, k_lin_reg, k_p_reg;
    logic signed [15:0] k_t_reg;
    assign k_t    = pdiv_rsp.side[16:1];
    assign k_high = pdiv_rsp.side[0];
    assign k_p    = $signed(k_high ? (pdiv_rsp.quot << 1) : pdiv_rsp.quot);
    assign k_pd   = sdiv_p2(k_p, 8);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_pdpd_reg <= k_pd * k_pd;
            k_lin_reg  <= P_LIN_COEF * k_p;
            k_p_reg    <= k_p;
            k_t_reg    <= k_t;
        end
    end

    // ---- Stage L: square term coefficient
    logic signed [31:0] l_m_reg, l_x2_reg, l_p_reg;
    logic signed [15:0] l_t_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_m_reg  <= k_pdpd_reg * P_SQ_COEF;
            l_x2_reg <= sdiv_p2(k_lin_reg, 16);
            l_p_reg  <= k_p_reg;
            l_t_reg  <= k_t_reg;
        end
    end

    // ---- Stage M: final pressure, saturation, output register
    logic signed [31:0] m_p;
    logic        [19:0] m_p_sat;
    logic signed [15:0] m_t_reg;
    logic        [19:0] m_p_reg;
    assign m_p = l_p_reg + sdiv_p2(sdiv_p2(l_m_reg, 16) + l_x2_reg + P_OFFSET, 4);

    always_comb
    begin
        if (m_p[31])
        begin
            m_p_sat = '0;
        end
        else if (m_p > $signed({12'd0, P_MAX}))
        begin
            m_p_sat = P_MAX;
        end
        else
        begin
            m_p_sat = m_p[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_t_reg <= l_t_reg;
            m_p_reg <= m_p_sat;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
            l_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= samples.valid;
            c_valid_reg <= tdiv_rsp.valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
            k_valid_reg <= pdiv_rsp.valid;
            l_valid_reg <= k_valid_reg;
            m_valid_reg <= l_valid_reg;
        end
    end

    assign results.valid              = m_valid_reg;
    assign results.temperature_tenths = m_t_reg;
    assign results.pressure_pa        = m_p_reg;

endmodule
`default_nettype wire

### bench/pressure_temperature_compensation_tb.sv
// Testbench for the pressure/temperature compensation block: directed and random samples.
`timescale 1ns / 1ps
module pressure_temperature_compensation_tb;
    import ptc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic signed [15:0] temperature_tenths;
        logic        [19:0] pressure_pa;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cal_index_t  cfg_index;
    logic [31:0] cfg_data;

    ptc_in_if  samples_if ();
    ptc_out_if results_if ();

    pressure_temperature_compensation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples_if.sink),
        .results   (results_if.source)
    );

    // Mirror of the calibration registers
    logic [31:0] cal_mirror [8];
    reading_t    expected_readings [$];
    int          error_count;
    int          idle_cycles;
    bit          no_idle;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Compensation arithmetic at 32-bit wrap, truncating divisions
    function automatic reading_t compensate(input logic [15:0] ut_raw, input logic [15:0] up_raw);
        int ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
        int unsigned ac4, b4, b7, q;
        int ut, x1, x2, x3, b3, b5, b6, sq, t, p, den;
        reading_t r;
        ut  = int'(ut_raw);
        ac1 = int'($signed(cal_mirror[REG_AC1][15:0]));
        ac2 = int'($signed(cal_mirror[REG_AC2][15:0]));
        ac3 = int'($signed(cal_mirror[REG_AC3][15:0]));
        ac4 = 32'(cal_mirror[REG_AC4][15:0]);
        ac5 = int'(cal_mirror[REG_AC5][15:0]);
        ac6 = int'(cal_mirror[REG_AC6][15:0]);
        b1  = int'($signed(cal_mirror[REG_B1_B2][31:16]));
        b2  = int'($signed(cal_mirror[REG_B1_B2][15:0]));
        mc  = int'($signed(cal_mirror[REG_MC_MD][31:16]));
        md  = int'($signed(cal_mirror[REG_MC_MD][15:0]));

        // temperature
        x1  = ((ut - ac6) * ac5) / 32768;
        den = x1 + md;
        x2  = (den == 0) ? 0 : (mc * 2048) / den;
        b5  = x1 + x2;
        t   = (b5 + 8) / 16;

        // pressure
        b6 = b5 - 4000;
        sq = (b6 * b6) / 4096;
        x1 = (b2 * sq) / 2048;
        x2 = (ac2 * b6) / 2048;
        x3 = x1 + x2;
        b3 = (ac1 * 4 + x3 + 2) / 4;
        x1 = (ac3 * b6) / 8192;
        x2 = (b1 * sq) / 65536;
        x3 = (x1 + x2 + 2) / 4;
        b4 = (ac4 * int'(unsigned'(x3 + 32768))) >> 15;
        b7 = (int'(unsigned'({16'd0, up_raw})) - unsigned'(b3)) * 32'd50000;
        if (b7 < 32'h8000_0000)
            q = (b4 == 0) ? 32'hffff_ffff : (b7 * 2) / b4;
        else
            q = ((b4 == 0) ? 32'hffff_ffff : b7 / b4) * 2;
        p  = int'(q);
        x1 = (p / 256) * (p / 256);
        x1 = (x1 * 3038) / 65536;
        x2 = (-7357 * p) / 65536;
        p  = p + (x1 + x2 + 3791) / 16;

        // saturation
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        if (p > 1048575)
            p = 1048575;
        if (p < 0)
            p = 0;
        r.temperature_tenths = t[15:0];
        r.pressure_pa        = p[19:0];
        return r;
    endfunction

    // Write one calibration register, only while idle
    task automatic write_cal(input cal_index_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        cal_mirror[idx] = (idx <= REG_AC6) ? {16'd0, data[15:0]} : data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_cal(input logic [31:0] v0, input logic [31:0] v1,
                                 input logic [31:0] v2, input logic [31:0] v3,
                                 input logic [31:0] v4, input logic [31:0] v5,
                                 input logic [31:0] v6, input logic [31:0] v7);
        write_cal(REG_AC1, v0);
        write_cal(REG_AC2, v1);
        write_cal(REG_AC3, v2);
        write_cal(REG_AC4, v3);
        write_cal(REG_AC5, v4);
        write_cal(REG_AC6, v5);
        write_cal(REG_B1_B2, v6);
        write_cal(REG_MC_MD, v7);
    endtask

    // Drop valid after the last transaction, then wait for every result
    task automatic wait_drained();
        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Send one sample transaction
    task automatic send_sample(input logic [15:0] ut, input logic [15:0] up);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            samples_if.valid <= 1'b0;
        end
        @(negedge clk);
        samples_if.valid           <= 1'b1;
        samples_if.raw_temperature <= ut;
        samples_if.raw_pressure    <= up;
        do
            @(posedge clk);
        while (!samples_if.ready);
        expected_readings.push_back(compensate(ut, up));
    endtask

    task automatic send_random(input int count);
        repeat (count)
        begin
            case ($urandom_range(0, 3))
                0: send_sample(16'($urandom), 16'($urandom));
                // near typical sensor readings
                1: send_sample(16'($urandom_range(20000, 36000)),
                               16'($urandom_range(15000, 45000)));
                2: send_sample(16'($urandom_range(0, 15) * 16'h1111), 16'($urandom));
                default: send_sample(16'($urandom), 16'($urandom_range(0, 15) * 16'h1111));
            endcase
        end
    endtask

    // Stock coefficients: field extremes and typical readings
    task automatic test_stock_extremes();
        send_sample(16'd0, 16'd0);
        send_sample(16'hffff, 16'hffff);
        send_sample(16'd0, 16'hffff);
        send_sample(16'hffff, 16'd0);
        send_sample(16'd27898, 16'd23843);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff);
        send_sample(16'h5555, 16'haaaa);
        send_sample(16'haaaa, 16'h5555);
        wait_drained();
    endtask

    // Zero temperature divisor and zero pressure divisor
    task automatic test_zero_divisors();
        int x1;
        x1 = ((27898 - int'(RST_AC6)) * int'(RST_AC5)) / 32768;
        write_cal(REG_MC_MD, {RST_MC_MD[31:16], 16'(-x1)});
        send_sample(16'd27898, 16'd23843);
        send_sample(16'd27898, 16'hffff);
        wait_drained();
        write_all_cal(0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(16'd0, 16'd0);
        send_sample(16'hffff, 16'hffff);
        send_sample(16'd1234, 16'd40000);
        wait_drained();
        write_all_cal(32'(RST_AC1), 32'(RST_AC2), 32'(RST_AC3), 32'(RST_AC4),
                      32'(RST_AC5), 32'(RST_AC6), RST_B1_B2, RST_MC_MD);
        write_cal(REG_AC4, 32'd0);
        send_sample(16'd27898, 16'd23843);
        send_sample(16'd27898, 16'd0);
        wait_drained();
    endtask

    // Random samples under several coefficient settings
    task automatic test_random_phases();
        write_all_cal(32'(RST_AC1), 32'(RST_AC2), 32'(RST_AC3), 32'(RST_AC4),
                      32'(RST_AC5), 32'(RST_AC6), RST_B1_B2, RST_MC_MD);
        send_random(200);
        wait_drained();
        write_all_cal(32'h7fff, 32'h7fff, 32'h7fff, 32'hffff, 32'hffff, 32'hffff,
                      32'h7fff_7fff, 32'h7fff_7fff);
        send_random(100);
        wait_drained();
        write_all_cal(32'h8000, 32'h8000, 32'h8000, 32'h0000, 32'h0000, 32'h0000,
                      32'h8000_8000, 32'h8000_8000);
        send_random(100);
        wait_drained();
        no_idle = 1'b1;
        write_all_cal(32'hffff, 32'hffff, 32'hffff, 32'h0001, 32'h0001, 32'h0001,
                      32'hffff_ffff, 32'h8000_7fff);
        send_random(100);
        wait_drained();
        no_idle = 1'b0;
        repeat (4)
        begin
            write_all_cal($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
            send_random(100);
            wait_drained();
        end
        no_idle = 1'b1;
        send_random(50);
        no_idle = 1'b0;
        send_random(50);
    endtask

    // Main sequence
    initial
    begin
        rst_n                      = 1'b0;
        cfg_we                     = 1'b0;
        cfg_index                  = REG_AC1;
        cfg_data                   = 32'd0;
        samples_if.valid           = 1'b0;
        samples_if.raw_temperature = 16'd0;
        samples_if.raw_pressure    = 16'd0;
        error_count                = 0;
        no_idle                    = 1'b0;
        cal_mirror[REG_AC1]   = {16'd0, RST_AC1};
        cal_mirror[REG_AC2]   = {16'd0, RST_AC2};
        cal_mirror[REG_AC3]   = {16'd0, RST_AC3};
        cal_mirror[REG_AC4]   = {16'd0, RST_AC4};
        cal_mirror[REG_AC5]   = {16'd0, RST_AC5};
        cal_mirror[REG_AC6]   = {16'd0, RST_AC6};
        cal_mirror[REG_B1_B2] = RST_B1_B2;
        cal_mirror[REG_MC_MD] = RST_MC_MD;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_stock_extremes();
        test_zero_divisors();
        test_random_phases();

        @(negedge clk);
        samples_if.valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls, compare each result transaction
    initial
    begin
        int stall;
        reading_t want;
        results_if.ready = 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            repeat (stall)
            begin
                @(negedge clk);
                results_if.ready <= 1'b0;
            end
            @(negedge clk);
            results_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(results_if.valid && rst_n));
            if (expected_readings.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("Unexpected result: temp %0d pressure %0d",
                             results_if.temperature_tenths, results_if.pressure_pa);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (results_if.temperature_tenths !== want.temperature_tenths ||
                    results_if.pressure_pa !== want.pressure_pa)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("Mismatch: temp exp %0d got %0d, pressure exp %0d got %0d",
                                 want.temperature_tenths, results_if.temperature_tenths,
                                 want.pressure_pa, results_if.pressure_pa);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

### filelist.f
hdl/ptc_pkg.sv
hdl/ptc_if.sv
hdl/ptc_div.sv
hdl/pressure_temperature_compensation.sv
bench/pressure_temperature_compensation_tb.sv
